### design/rgb_led_blink_sequencer_core_macros.svh
// assertion helpers shared by the rgb led blink sequencer
`ifndef RGB_LED_BLINK_SEQUENCER_CORE_MACROS_SVH
`define RGB_LED_BLINK_SEQUENCER_CORE_MACROS_SVH

// same-cycle implication
`define RLBS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RLBS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/rlbs_pkg.sv
`default_nettype none

package rlbs_pkg;

   localparam int ACTION_W    = 2;
   localparam int ROLE_W      = 2;
   localparam int LEVEL_W     = 8;
   localparam int RGB_W       = 3 * LEVEL_W;
   localparam int COMPARE_W   = 16;
   localparam int PERIOD_W    = 8;
   localparam int PERIOD_MS_W = 12;
   localparam int ELAPSED_W   = 12;
   localparam int PHASES_W    = 10;
   localparam int REPEAT_W    = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int LED_SLOTS   = 2;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK        = 2'd0,
      ACT_STEADY      = 2'd1,
      ACT_BLINK       = 2'd2,
      ACT_BY_FUNCTION = 2'd3
   } action_type;

   localparam logic [ROLE_W-1:0] ROLE_UNUSED = 2'd0;
   localparam logic [ROLE_W-1:0] ROLE_USER   = 2'd2;

   localparam logic [ROLE_W-1:0] FIRST_ROLE_RESET  = 2'd1;
   localparam logic [ROLE_W-1:0] SECOND_ROLE_RESET = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_FUNCTION  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_FUNCTION = 1'b1;

   localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX    = 12'd4095;
   localparam logic [REPEAT_W-1:0]    FOREVER_REPEAT = 8'hFF;
   localparam logic [PHASES_W-1:0]    FOREVER_RELOAD = 10'd256;
   localparam logic [PERIOD_MS_W-1:0] PERIOD_UNIT_MS = 12'd10;
   localparam logic [COMPARE_W-1:0]   COMPARE_FULL   = 16'd65535;

   localparam logic [COMPARE_W-1:0] GAMMA_TABLE [256] = '{
      16'd65535,16'd65508,16'd65479,16'd65451,16'd65422,16'd65394,16'd65365,16'd65337,
      16'd65308,16'd65280,16'd65251,16'd65223,16'd65195,16'd65166,16'd65138,16'd65109,
      16'd65081,16'd65052,16'd65024,16'd64995,16'd64967,16'd64938,16'd64909,16'd64878,
      16'd64847,16'd64815,16'd64781,16'd64747,16'd64711,16'd64675,16'd64637,16'd64599,
      16'd64559,16'd64518,16'd64476,16'd64433,16'd64389,16'd64344,16'd64297,16'd64249,
      16'd64200,16'd64150,16'd64099,16'd64046,16'd63992,16'd63937,16'd63880,16'd63822,
      16'd63763,16'd63702,16'd63640,16'd63577,16'd63512,16'd63446,16'd63379,16'd63310,
      16'd63239,16'd63167,16'd63094,16'd63019,16'd62943,16'd62865,16'd62785,16'd62704,
      16'd62621,16'd62537,16'd62451,16'd62364,16'd62275,16'd62184,16'd62092,16'd61998,
      16'd61902,16'd61804,16'd61705,16'd61604,16'd61501,16'd61397,16'd61290,16'd61182,
      16'd61072,16'd60961,16'd60847,16'd60732,16'd60614,16'd60495,16'd60374,16'd60251,
      16'd60126,16'd59999,16'd59870,16'd59739,16'd59606,16'd59471,16'd59334,16'd59195,
      16'd59053,16'd58910,16'd58765,16'd58618,16'd58468,16'd58316,16'd58163,16'd58007,
      16'd57848,16'd57688,16'd57525,16'd57361,16'd57194,16'd57024,16'd56853,16'd56679,
      16'd56503,16'd56324,16'd56143,16'd55960,16'd55774,16'd55586,16'd55396,16'd55203,
      16'd55008,16'd54810,16'd54610,16'd54408,16'd54203,16'd53995,16'd53785,16'd53572,
      16'd53357,16'd53140,16'd52919,16'd52696,16'd52471,16'd52243,16'd52012,16'd51778,
      16'd51542,16'd51304,16'd51062,16'd50818,16'd50571,16'd50321,16'd50069,16'd49813,
      16'd49555,16'd49295,16'd49031,16'd48764,16'd48495,16'd48223,16'd47948,16'd47670,
      16'd47389,16'd47105,16'd46818,16'd46529,16'd46236,16'd45940,16'd45641,16'd45340,
      16'd45035,16'd44727,16'd44416,16'd44102,16'd43785,16'd43465,16'd43142,16'd42815,
      16'd42486,16'd42153,16'd41817,16'd41478,16'd41135,16'd40790,16'd40441,16'd40089,
      16'd39733,16'd39375,16'd39013,16'd38647,16'd38279,16'd37907,16'd37531,16'd37153,
      16'd36770,16'd36385,16'd35996,16'd35603,16'd35207,16'd34808,16'd34405,16'd33999,
      16'd33589,16'd33175,16'd32758,16'd32338,16'd31913,16'd31486,16'd31054,16'd30619,
      16'd30181,16'd29738,16'd29292,16'd28843,16'd28389,16'd27932,16'd27471,16'd27007,
      16'd26539,16'd26066,16'd25590,16'd25111,16'd24627,16'd24140,16'd23649,16'd23153,
      16'd22654,16'd22152,16'd21645,16'd21134,16'd20619,16'd20101,16'd19578,16'd19051,
      16'd18521,16'd17986,16'd17447,16'd16905,16'd16358,16'd15807,16'd15252,16'd14693,
      16'd14129,16'd13562,16'd12990,16'd12415,16'd11835,16'd11251,16'd10662,16'd10070,
      16'd9473, 16'd8872, 16'd8266, 16'd7657, 16'd7043, 16'd6424, 16'd5802, 16'd5175,
      16'd4543, 16'd3908, 16'd3267, 16'd2623, 16'd1974, 16'd1320, 16'd662,  16'd0
   };

   // colour level to pwm compare value
   function automatic logic [COMPARE_W-1:0] pwm_compare(input logic [LEVEL_W-1:0] level);
      return COMPARE_FULL - GAMMA_TABLE[level];
   endfunction

endpackage

`default_nettype wire

### design/rlbs_if.sv
`default_nettype none

// command word into the sequencer
interface rlbs_req_if import rlbs_pkg::*;;
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic                led_index;
   logic [ROLE_W-1:0]   target_function;
   logic [REPEAT_W-1:0] blink_repeat;
   logic [LEVEL_W-1:0]  first_red;
   logic [LEVEL_W-1:0]  first_green;
   logic [LEVEL_W-1:0]  first_blue;
   logic [PERIOD_W-1:0] first_period;
   logic [LEVEL_W-1:0]  second_red;
   logic [LEVEL_W-1:0]  second_green;
   logic [LEVEL_W-1:0]  second_blue;
   logic [PERIOD_W-1:0] second_period;

   modport source (
      output valid, action, led_index, target_function, blink_repeat,
             first_red, first_green, first_blue, first_period,
             second_red, second_green, second_blue, second_period,
      input  ready
   );
   modport sink (
      input  valid, action, led_index, target_function, blink_repeat,
             first_red, first_green, first_blue, first_period,
             second_red, second_green, second_blue, second_period,
      output ready
   );
endinterface

// pwm compare word out of the sequencer
interface rlbs_rsp_if import rlbs_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [COMPARE_W-1:0] led0_red_compare;
   logic [COMPARE_W-1:0] led0_green_compare;
   logic [COMPARE_W-1:0] led0_blue_compare;
   logic [COMPARE_W-1:0] led1_red_compare;
   logic [COMPARE_W-1:0] led1_green_compare;
   logic [COMPARE_W-1:0] led1_blue_compare;
   logic                 led0_blinking;
   logic                 led1_blinking;

   modport source (
      output valid, led0_red_compare, led0_green_compare, led0_blue_compare,
             led1_red_compare, led1_green_compare, led1_blue_compare,
             led0_blinking, led1_blinking,
      input  ready
   );
   modport sink (
      input  valid, led0_red_compare, led0_green_compare, led0_blue_compare,
             led1_red_compare, led1_green_compare, led1_blue_compare,
             led0_blinking, led1_blinking,
      output ready
   );
endinterface

// register write word
interface rlbs_csr_if import rlbs_pkg::*;;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] reg_index;
   logic [ROLE_W-1:0]      write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

`default_nettype wire

### design/rgb_led_blink_sequencer_core.sv
// the compare word of an accepted command word is registered and valid in the next cycle
// throughput: one word per cycle, set by the single output register; a stalled
// output word holds back the input only while it is still untaken
// reset (synchronous, active high): all led state clears, the compares are not reset,
// led 0 role returns to FIRST_ROLE_RESET and led 1 role to user, no output word pending
`default_nettype none

`include "rgb_led_blink_sequencer_core_macros.svh"

module rgb_led_blink_sequencer_core
   import rlbs_pkg::*;
#(
   parameter int LED_COUNT = 2
) (
   input  wire            clock,
   input  wire            reset,
   rlbs_req_if.sink       req_chan,
   rlbs_rsp_if.source     rsp_chan,
   rlbs_csr_if.sink       csr_chan
);

   // ---------------------------------------------------------------
   // handshakes
   // ---------------------------------------------------------------
   logic rsp_valid_ff;
   logic req_accept;

   // take a new word when the output register is empty or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // ---------------------------------------------------------------
   // role registers
   // ---------------------------------------------------------------
   logic [ROLE_W-1:0] role_ff [LED_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff[0] <= FIRST_ROLE_RESET;
         role_ff[1] <= SECOND_ROLE_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.reg_index)
            CSR_FIRST_FUNCTION:  role_ff[0] <= csr_chan.write_data;
            CSR_SECOND_FUNCTION: role_ff[1] <= csr_chan.write_data;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // decoded command word, shared by both leds
   // ---------------------------------------------------------------
   action_type             action;
   logic [RGB_W-1:0]       colour_a;
   logic [RGB_W-1:0]       colour_b;
   logic [PERIOD_MS_W-1:0] period_a_ms;
   logic [PERIOD_MS_W-1:0] period_b_ms;
   logic [PHASES_W-1:0]    phases_start;

   assign action       = action_type'(req_chan.action);
   assign colour_a     = {req_chan.first_red, req_chan.first_green, req_chan.first_blue};
   assign colour_b     = {req_chan.second_red, req_chan.second_green, req_chan.second_blue};
   // periods come in 10 ms units
   assign period_a_ms  = PERIOD_MS_W'(req_chan.first_period) * PERIOD_UNIT_MS;
   assign period_b_ms  = PERIOD_MS_W'(req_chan.second_period) * PERIOD_UNIT_MS;
   // two phases per blink cycle
   assign phases_start = {1'b0, req_chan.blink_repeat, 1'b0};

   // ---------------------------------------------------------------
   // per-led sequencer state
   // ---------------------------------------------------------------
   logic [RGB_W-1:0]       steady_ff   [LED_SLOTS];
   logic [RGB_W-1:0]       steady_in   [LED_SLOTS];
   logic [REPEAT_W-1:0]    repeat_ff   [LED_SLOTS];
   logic [REPEAT_W-1:0]    repeat_in   [LED_SLOTS];
   logic [RGB_W-1:0]       col_one_ff  [LED_SLOTS];
   logic [RGB_W-1:0]       col_one_in  [LED_SLOTS];
   logic [RGB_W-1:0]       col_two_ff  [LED_SLOTS];
   logic [RGB_W-1:0]       col_two_in  [LED_SLOTS];
   logic [PERIOD_MS_W-1:0] per_one_ff  [LED_SLOTS];
   logic [PERIOD_MS_W-1:0] per_one_in  [LED_SLOTS];
   logic [PERIOD_MS_W-1:0] per_two_ff  [LED_SLOTS];
   logic [PERIOD_MS_W-1:0] per_two_in  [LED_SLOTS];
   logic [PHASES_W-1:0]    phases_ff   [LED_SLOTS];
   logic [PHASES_W-1:0]    phases_in   [LED_SLOTS];
   logic [ELAPSED_W-1:0]   elapsed_ff  [LED_SLOTS];
   logic [ELAPSED_W-1:0]   elapsed_in  [LED_SLOTS];
   // colour on show; its gamma compare is what the led drives
   logic [RGB_W-1:0]       shown_ff    [LED_SLOTS];
   logic [RGB_W-1:0]       shown_in    [LED_SLOTS];

   for (genvar n = 0; n < LED_SLOTS; n++) begin : g_led
      localparam bit Present = (n < LED_COUNT);

      logic [ELAPSED_W-1:0] elapsed_inc;
      logic [PHASES_W-1:0]  phases_dec;
      logic                 addressed;

      // saturating millisecond count
      assign elapsed_inc = (elapsed_ff[n] == ELAPSED_MAX) ? ELAPSED_MAX
                                                          : elapsed_ff[n] + 1'b1;
      assign phases_dec  = phases_ff[n] - 1'b1;
      assign addressed   = (req_chan.led_index == 1'(n));

      always_comb begin
         steady_in[n]  = steady_ff[n];
         repeat_in[n]  = repeat_ff[n];
         col_one_in[n] = col_one_ff[n];
         col_two_in[n] = col_two_ff[n];
         per_one_in[n] = per_one_ff[n];
         per_two_in[n] = per_two_ff[n];
         phases_in[n]  = phases_ff[n];
         elapsed_in[n] = elapsed_ff[n];
         shown_in[n]   = shown_ff[n];
         if (req_accept && Present) begin
            case (action)
               ACT_TICK: begin
                  elapsed_in[n] = elapsed_inc;
                  if (phases_ff[n] != '0) begin
                     if (phases_ff[n][0]) begin
                        // colour two phase
                        if (elapsed_inc >= per_two_ff[n]) begin
                           elapsed_in[n] = '0;
                           phases_in[n]  = phases_dec;
                           if (phases_dec != '0) begin
                              shown_in[n] = col_one_ff[n];
                           end else if (repeat_ff[n] == FOREVER_REPEAT) begin
                              // endless blink wraps back to colour one
                              phases_in[n] = FOREVER_RELOAD;
                              shown_in[n]  = col_one_ff[n];
                           end else begin
                              shown_in[n] = steady_ff[n];
                           end
                        end
                     end else if (elapsed_inc >= per_one_ff[n]) begin
                        // colour one phase over
                        shown_in[n]   = col_two_ff[n];
                        elapsed_in[n] = '0;
                        phases_in[n]  = phases_dec;
                     end
                  end
               end
               ACT_STEADY: begin
                  // only a user led takes a steady colour; a running blink goes on
                  if (addressed && role_ff[n] == ROLE_USER) begin
                     steady_in[n] = colour_a;
                     shown_in[n]  = colour_a;
                  end
               end
               ACT_BLINK: begin
                  if (addressed && role_ff[n] != ROLE_UNUSED) begin
                     repeat_in[n]  = req_chan.blink_repeat;
                     phases_in[n]  = phases_start;
                     col_one_in[n] = colour_a;
                     col_two_in[n] = colour_b;
                     per_one_in[n] = period_a_ms;
                     per_two_in[n] = period_b_ms;
                     if (req_chan.blink_repeat != '0) begin
                        shown_in[n]   = colour_a;
                        elapsed_in[n] = '0;
                     end else begin
                        // zero repeat stores the blink but shows steady
                        shown_in[n] = steady_ff[n];
                     end
                  end
               end
               ACT_BY_FUNCTION: begin
                  if (role_ff[n] == req_chan.target_function) begin
                     steady_in[n] = colour_a;
                     repeat_in[n] = '0;
                     phases_in[n] = '0;
                     shown_in[n]  = colour_a;
                  end
               end
               default: ;
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            steady_ff[n]  <= '0;
            repeat_ff[n]  <= '0;
            col_one_ff[n] <= '0;
            col_two_ff[n] <= '0;
            per_one_ff[n] <= '0;
            per_two_ff[n] <= '0;
            phases_ff[n]  <= '0;
            elapsed_ff[n] <= '0;
            shown_ff[n]   <= '0;
         end else begin
            steady_ff[n]  <= steady_in[n];
            repeat_ff[n]  <= repeat_in[n];
            col_one_ff[n] <= col_one_in[n];
            col_two_ff[n] <= col_two_in[n];
            per_one_ff[n] <= per_one_in[n];
            per_two_ff[n] <= per_two_in[n];
            phases_ff[n]  <= phases_in[n];
            elapsed_ff[n] <= elapsed_in[n];
            shown_ff[n]   <= shown_in[n];
         end
      end
   end

   // ---------------------------------------------------------------
   // output register: gamma compares of the colours after this word
   // ---------------------------------------------------------------
   logic [COMPARE_W-1:0] red_cmp_ff   [LED_SLOTS];
   logic [COMPARE_W-1:0] green_cmp_ff [LED_SLOTS];
   logic [COMPARE_W-1:0] blue_cmp_ff  [LED_SLOTS];
   logic                 blinking_ff  [LED_SLOTS];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // compare payload; an absent led never leaves colour zero, which maps to zero
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < LED_SLOTS; i++) begin
            red_cmp_ff[i]   <= pwm_compare(shown_in[i][RGB_W-1 -: LEVEL_W]);
            green_cmp_ff[i] <= pwm_compare(shown_in[i][LEVEL_W +: LEVEL_W]);
            blue_cmp_ff[i]  <= pwm_compare(shown_in[i][0 +: LEVEL_W]);
            blinking_ff[i]  <= (phases_in[i] != '0);
         end
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.led0_red_compare   = red_cmp_ff[0];
   assign rsp_chan.led0_green_compare = green_cmp_ff[0];
   assign rsp_chan.led0_blue_compare  = blue_cmp_ff[0];
   assign rsp_chan.led1_red_compare   = red_cmp_ff[1];
   assign rsp_chan.led1_green_compare = green_cmp_ff[1];
   assign rsp_chan.led1_blue_compare  = blue_cmp_ff[1];
   assign rsp_chan.led0_blinking      = blinking_ff[0];
   assign rsp_chan.led1_blinking      = blinking_ff[1];

   // ---------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------
   // state only moves with an accepted word, so a pending word mirrors it
   `RLBS_ASSERT_NOW(a_led0_blink_flag, clock, reset, rsp_valid_ff, blinking_ff[0] == (phases_ff[0] != '0), "led 0 blinking flag disagrees with phase count")
   `RLBS_ASSERT_NOW(a_led1_blink_flag, clock, reset, rsp_valid_ff, blinking_ff[1] == (phases_ff[1] != '0), "led 1 blinking flag disagrees with phase count")
   // phase count never passes two phases per loop of the longest blink
   `RLBS_ASSERT_NOW(a_phase_bound, clock, reset, 1'b1, (phases_ff[0] <= 10'd510) && (phases_ff[1] <= 10'd510), "phase count out of range")
   // a stalled output word blocks new input
   `RLBS_ASSERT_NOW(a_no_overrun, clock, reset, rsp_valid_ff && !rsp_chan.ready, !req_chan.ready, "input taken over a stalled output word")
   // every accepted word leaves a result pending
   `RLBS_ASSERT_NEXT(a_result_follows, clock, reset, req_accept, rsp_valid_ff, "accepted word produced no result")

endmodule

`default_nettype wire
